[rtl/rkc_pkg.sv]
// Shared types and codes for the reference-counted key cache table.
// Used by rkc_cell, refcounted_key_cache_table and rkc_checker.
package rkc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int ST_W    = 3;
  localparam int MODE_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

  localparam logic [ST_W-1:0] ST_HIT      = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd2;
  localparam logic [ST_W-1:0] ST_HELD     = 3'd3;
  localparam logic [ST_W-1:0] ST_FREED    = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;
  localparam logic [ST_W-1:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic              exec;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic              any_hit;
  } rkc_cmd_t;

  typedef struct packed {
    logic              hit_seen;
    logic              free_seen;
    logic              act;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } rkc_link_t;

endpackage

[rtl/rkc_cell.sv]
// One table slot: valid bit, key and reference count, with its share of the
// priority chain toward the next slot. Depends on rkc_pkg.
module rkc_cell import rkc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rkc_cmd_t          cmd,
  input  logic [SLOT_W-1:0] cell_idx,
  input  rkc_link_t         lnk_i,
  output rkc_link_t         lnk_o,
  output logic              match_o
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             win_hit, win_free, act;
  logic [ST_W-1:0]  own_st;
  logic [CNT_W-1:0] own_cnt;

  assign match_o  = valid_r && (key_r == cmd.key);
  assign win_hit  = match_o && !lnk_i.hit_seen;
  assign win_free = !valid_r && !lnk_i.free_seen && !cmd.any_hit
                    && (cmd.mode == MODE_INSERT);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    act       = 1'b0;
    own_st    = ST_MISS;
    own_cnt   = '0;
    case (cmd.mode)
      MODE_LOOKUP, MODE_INSERT: begin
        if (win_hit) begin
          act     = 1'b1;
          cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
          own_st  = ST_HIT;
          own_cnt = cnt_nxt;
        end else if (win_free) begin
          act       = 1'b1;
          valid_nxt = 1'b1;
          key_nxt   = cmd.key;
          cnt_nxt   = CNT_W'(1);
          own_st    = ST_INSERTED;
          own_cnt   = CNT_W'(1);
        end
      end
      MODE_RELEASE: begin
        if (win_hit) begin
          act = 1'b1;
          if (cnt_r <= CNT_W'(1)) begin
            valid_nxt = 1'b0;
            cnt_nxt   = '0;
            own_st    = ST_FREED;
            own_cnt   = '0;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            own_st  = ST_HELD;
            own_cnt = cnt_nxt;
          end
        end
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    lnk_o.hit_seen  = lnk_i.hit_seen || match_o;
    lnk_o.free_seen = lnk_i.free_seen || !valid_r;
    lnk_o.act       = lnk_i.act || act;
    lnk_o.status    = act ? own_st  : lnk_i.status;
    lnk_o.slot      = act ? cell_idx : lnk_i.slot;
    lnk_o.count     = act ? own_cnt : lnk_i.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      key_r <= key_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/refcounted_key_cache_table.sv]
// Reference-counted key cache table: a row of rkc_cell slots with a request
// register in front and an output register behind. Depends on rkc_pkg, rkc_cell.
// An item is held in the request register, then one compare-and-update pass over
// the row writes the output register; a new item is accepted only after that pass.
// A waiting result does not block the next accept; execution waits for it.
// Reset (synchronous, rst_n low) empties the table and drops any pending item.
module refcounted_key_cache_table import rkc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ST_W-1:0]     out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [CNT_W-1:0]    out_ref_count
);

  logic              busy_r;
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              exec;
  rkc_cmd_t          cmd;
  rkc_link_t         lnk [ENTRIES+1];
  logic [ENTRIES-1:0] match;

  assign in_ready = !busy_r;
  assign exec     = busy_r && (!out_valid_r || out_ready);

  assign cmd.exec    = exec;
  assign cmd.mode    = mode_r;
  assign cmd.key     = key_r;
  assign cmd.any_hit = |match;

  assign lnk[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rkc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .cell_idx (SLOT_W'(i)),
      .lnk_i    (lnk[i]),
      .lnk_o    (lnk[i+1]),
      .match_o  (match[i])
    );
  end

  always_comb begin
    slot_nxt = '0;
    cnt_nxt  = '0;
    if (mode_r == MODE_CLEAR) begin
      st_nxt = ST_CLEARED;
    end else if (lnk[ENTRIES].act) begin
      st_nxt   = lnk[ENTRIES].status;
      slot_nxt = lnk[ENTRIES].slot;
      cnt_nxt  = lnk[ENTRIES].count;
    end else if (mode_r == MODE_INSERT) begin
      st_nxt = ST_FULL;
    end else begin
      st_nxt = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
    if (exec) begin
      st_r   <= st_nxt;
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = st_r;
  assign out_slot      = slot_r;
  assign out_ref_count = cnt_r;

endmodule

[rtl/rkc_checker.sv]
// Port-level checks for refcounted_key_cache_table, bound to the top level.
// Depends on rkc_pkg.
module rkc_checker import rkc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ST_W-1:0]   out_status,
  input logic [SLOT_W-1:0] out_slot,
  input logic [CNT_W-1:0]  out_ref_count
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output valid or input blocked after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_slot) && $stable(out_ref_count))
    else $error("stalled item changed");

  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISS || out_status == ST_FULL
      || out_status == ST_CLEARED || out_status == ST_FREED)
    |-> out_ref_count == '0 && (out_status == ST_FREED || out_slot == '0))
    else $error("nonzero count or slot without an entry");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INSERTED || out_status == ST_HELD
      || out_status == ST_HIT)
    |-> out_ref_count != '0 && (out_status != ST_INSERTED || out_ref_count == CNT_W'(1)))
    else $error("count inconsistent with status");

endmodule

bind refcounted_key_cache_table rkc_checker u_rkc_checker (.*);
